// File: rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// check clocked on i_clk, off while reset is low
`define P1_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check clocked on i_clk, live through reset
`define P1_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define P1_ASSERT(lbl, prop, msg)
`define P1_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/p1tri_pkg.sv
// ============================================================================
// p1tri_pkg
// Widths, record types and saturation helper for the P1 triangle stiffness.
// ============================================================================
`timescale 1ns / 1ps
package p1tri_pkg;

    localparam int CW                  = 24;   // coordinate / area width
    localparam int OW                  = 32;   // Q16.16 result width
    localparam int OUT_FRAC            = 16;
    localparam int QW                  = OW + 2; // quotient bits incl. overflow
    localparam int NROW                = 3;
    localparam int DEF_COORD_FRAC_BITS = 16;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_MID   = 2'd1;
    localparam logic [1:0] ROW_LAST  = 2'd2;

    localparam logic signed [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};
    localparam logic [63:0] MAG_POS_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MAG_NEG_MAX = 64'h0000_0000_8000_0000;

    // per-row side data alongside the divider
    typedef struct packed {
        logic [1:0]    row;
        logic [CW-1:0] area;
        logic          degen;
        logic [2:0]    neg;   // quotient signs: a, b, c
    } t_meta;

    // one stiffness row at work
    typedef struct packed {
        logic [1:0]           row;
        logic signed [OW-1:0] a;
        logic signed [OW-1:0] b;
        logic signed [OW-1:0] c;
        logic                 degen;
        logic [CW-1:0]        area;
    } t_krow;

    // finished result item
    typedef struct packed {
        logic [1:0]                row;
        logic signed [OW-1:0]      a;
        logic signed [OW-1:0]      b;
        logic signed [OW-1:0]      c;
        logic [NROW-1:0][OW-1:0]   k;
        logic                      degen;
        logic                      last;
    } t_res;

    // sign-magnitude to saturated 32-bit two's complement
    function automatic logic signed [OW-1:0] sat32(input logic neg, input logic [63:0] mag,
                                                   input logic sat);
        logic signed [OW-1:0] res;
        if (neg) begin
            if (sat || mag > MAG_NEG_MAX) res = SAT_NEG;
            else                          res = -mag[OW-1:0];
        end else begin
            if (sat || mag > MAG_POS_MAX) res = SAT_POS;
            else                          res = mag[OW-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/p1tri_divider.sv
// ============================================================================
// p1tri_divider
// Pipelined restoring divider, one quotient bit per stage, lanes share divisor.
// ============================================================================
`timescale 1ns / 1ps
module p1tri_divider #(
    parameter int DW = 50,
    parameter int NS = 34,
    parameter int NL = 3
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [NL-1:0][DW+NS-1:0]    i_num,
    input  logic [DW-1:0]               i_den,
    output logic [NL-1:0][NS-1:0]       o_q
);
    localparam int XW = DW + NS;

    logic [NL-1:0][XW-1:0] r_rem [NS-1];
    logic [DW-1:0]         r_den [NS-1];
    logic [NL-1:0][NS-1:0] r_q   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        localparam int K = NS - 1 - s;
        logic [NL-1:0][XW-1:0] w_rem_in;
        logic [DW-1:0]         w_den_in;
        logic [NL-1:0][NS-1:0] w_q_in;
        logic [NL-1:0][XW-1:0] n_rem;
        logic [NL-1:0][NS-1:0] n_q;
        logic [XW-1:0]         w_dsh;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        assign w_dsh = XW'(w_den_in) << K;

        // trial subtract of the shifted divisor
        always_comb begin
            logic [XW:0] v_sub;
            n_rem = w_rem_in;
            n_q   = '0;
            for (int l = 0; l < NL; l++) begin
                v_sub    = {1'b0, w_rem_in[l]} - {1'b0, w_dsh};
                n_q[l]   = {w_q_in[l][NS-2:0], ~v_sub[XW]};
                if (!v_sub[XW]) n_rem[l] = v_sub[XW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) r_q[s] <= n_q;
        end

        if (s < NS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_den[s] <= w_den_in;
                end
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule

// File: rtl/p1_triangle_element_stiffness.sv
// ============================================================================
// p1_triangle_element_stiffness
// Linear triangle basis coefficients and local stiffness rows, pipelined.
// ============================================================================
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  in       | i_in_valid / o_in_ready    | three vertices, element area
//  out      | o_out_valid / i_out_ready  | one stiffness row, coefficients
//
// Each accepted element is split into three rows that enter the pipeline
// one per cycle while it is not held; the next element can be accepted as the
// last row enters, so the output row rate sets the pace. The divider has 34
// stages. Reset clears the valid bits and row counters only. A stalled output
// fills one skid register, after which the whole pipeline holds in place.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module p1_triangle_element_stiffness #(
    parameter int COORD_FRAC_BITS = p1tri_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [p1tri_pkg::CW-1:0]   i_vertex0_x,
    input  logic signed [p1tri_pkg::CW-1:0]   i_vertex0_y,
    input  logic signed [p1tri_pkg::CW-1:0]   i_vertex1_x,
    input  logic signed [p1tri_pkg::CW-1:0]   i_vertex1_y,
    input  logic signed [p1tri_pkg::CW-1:0]   i_vertex2_x,
    input  logic signed [p1tri_pkg::CW-1:0]   i_vertex2_y,
    input  logic [p1tri_pkg::CW-1:0]          i_element_area,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_vertex_row,
    output logic signed [p1tri_pkg::OW-1:0]   o_coef_const,
    output logic signed [p1tri_pkg::OW-1:0]   o_coef_x,
    output logic signed [p1tri_pkg::OW-1:0]   o_coef_y,
    output logic signed [p1tri_pkg::OW-1:0]   o_stiff_col0,
    output logic signed [p1tri_pkg::OW-1:0]   o_stiff_col1,
    output logic signed [p1tri_pkg::OW-1:0]   o_stiff_col2,
    output logic                              o_degenerate,
    output logic                              o_last_row
);
    import p1tri_pkg::*;

    localparam int DW    = 2 * CW + 2;                       // divisor magnitude
    localparam int NS    = QW;                               // divider stages
    localparam int XW    = DW + NS;
    localparam int SH_A  = OUT_FRAC + 1;
    localparam int SH_BC = COORD_FRAC_BITS + OUT_FRAC + 1;
    localparam int SH_K  = COORD_FRAC_BITS + OUT_FRAC;
    localparam int PW    = CW + OW;                          // area partial product
    localparam int TW    = CW + 2 * OW + 1;
    localparam logic [TW-1:0] RND_K = TW'(1) << (SH_K - 1);

    // pipeline enable: hold everything once the skid register is occupied
    logic r_skid_v;
    logic w_en;
    logic w_in_acc;
    assign w_en = ~r_skid_v;

    // ---------------- serializer: one element to three rows ----------------
    logic                 r_ser_v;
    logic [1:0]           r_ser_cnt;
    logic signed [CW-1:0] r_ser_x [NROW];
    logic signed [CW-1:0] r_ser_y [NROW];
    logic [CW-1:0]        r_ser_area;

    assign o_in_ready = w_en && (!r_ser_v || r_ser_cnt == ROW_LAST);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v   <= 1'b0;
            r_ser_cnt <= ROW_FIRST;
        end else if (w_en) begin
            if (r_ser_v && r_ser_cnt != ROW_LAST) begin
                r_ser_cnt <= r_ser_cnt + 2'd1;
            end else begin
                r_ser_v   <= w_in_acc;
                r_ser_cnt <= ROW_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ser_x[0] <= i_vertex0_x;
            r_ser_y[0] <= i_vertex0_y;
            r_ser_x[1] <= i_vertex1_x;
            r_ser_y[1] <= i_vertex1_y;
            r_ser_x[2] <= i_vertex2_x;
            r_ser_y[2] <= i_vertex2_y;
            r_ser_area <= i_element_area;
        end
    end

    // ---------------- stage A: vertex selection and differences ----------------
    logic                 r_av;
    t_meta                r_am, n_am;
    logic signed [CW-1:0] r_xj, r_yj, r_xk, r_yk, n_xj, n_yj, n_xk, n_yk;
    logic signed [CW:0]   r_dx1, r_dy2, r_dx2, r_dy1;
    logic signed [CW:0]   r_a_bn, r_a_cn, n_a_bn, n_a_cn;

    // row i uses the next two vertices in cyclic order
    always_comb begin
        unique case (r_ser_cnt)
            ROW_MID: begin
                n_xj = r_ser_x[2]; n_yj = r_ser_y[2];
                n_xk = r_ser_x[0]; n_yk = r_ser_y[0];
            end
            ROW_LAST: begin
                n_xj = r_ser_x[0]; n_yj = r_ser_y[0];
                n_xk = r_ser_x[1]; n_yk = r_ser_y[1];
            end
            default: begin
                n_xj = r_ser_x[1]; n_yj = r_ser_y[1];
                n_xk = r_ser_x[2]; n_yk = r_ser_y[2];
            end
        endcase
        n_a_bn     = {n_yj[CW-1], n_yj} - {n_yk[CW-1], n_yk};
        n_a_cn     = {n_xk[CW-1], n_xk} - {n_xj[CW-1], n_xj};
        n_am       = '0;
        n_am.row   = r_ser_cnt;
        n_am.area  = r_ser_area;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_am   <= n_am;
            r_xj   <= n_xj;
            r_yj   <= n_yj;
            r_xk   <= n_xk;
            r_yk   <= n_yk;
            r_a_bn <= n_a_bn;
            r_a_cn <= n_a_cn;
            r_dx1  <= {r_ser_x[1][CW-1], r_ser_x[1]} - {r_ser_x[0][CW-1], r_ser_x[0]};
            r_dy2  <= {r_ser_y[2][CW-1], r_ser_y[2]} - {r_ser_y[0][CW-1], r_ser_y[0]};
            r_dx2  <= {r_ser_x[2][CW-1], r_ser_x[2]} - {r_ser_x[0][CW-1], r_ser_x[0]};
            r_dy1  <= {r_ser_y[1][CW-1], r_ser_y[1]} - {r_ser_y[0][CW-1], r_ser_y[0]};
        end
    end

    // ---------------- stage B: products ----------------
    logic                     r_bv;
    t_meta                    r_bm;
    logic signed [2*CW+1:0]   r_pd1, r_pd2;
    logic signed [2*CW-1:0]   r_pa1, r_pa2;
    logic signed [CW:0]       r_b_bn, r_b_cn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bm   <= r_am;
            r_pd1  <= r_dx1 * r_dy2;
            r_pd2  <= r_dx2 * r_dy1;
            r_pa1  <= r_xj * r_yk;
            r_pa2  <= r_xk * r_yj;
            r_b_bn <= r_a_bn;
            r_b_cn <= r_a_cn;
        end
    end

    // ---------------- stage C: determinant and constant numerator ----------------
    logic                   r_cv;
    t_meta                  r_cm;
    logic signed [2*CW+2:0] r_det;
    logic signed [2*CW:0]   r_an;
    logic signed [CW:0]     r_c_bn, r_c_cn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cm   <= r_bm;
            r_det  <= {r_pd1[2*CW+1], r_pd1} - {r_pd2[2*CW+1], r_pd2};
            r_an   <= {r_pa1[2*CW-1], r_pa1} - {r_pa2[2*CW-1], r_pa2};
            r_c_bn <= r_b_bn;
            r_c_cn <= r_b_cn;
        end
    end

    // ---------------- stage D: sign-magnitude and scaling ----------------
    logic                     r_dv;
    t_meta                    r_dm, n_dm;
    logic [NROW-1:0][XW-1:0]  r_num, n_num;
    logic [DW-1:0]            r_den, n_den;

    always_comb begin
        logic [2*CW+2:0] v_dabs;
        logic [2*CW:0]   v_aabs;
        logic [CW:0]     v_babs, v_cabs;
        v_dabs = r_det[2*CW+2]  ? -r_det  : r_det;
        v_aabs = r_an[2*CW]     ? -r_an   : r_an;
        v_babs = r_c_bn[CW]     ? -r_c_bn : r_c_bn;
        v_cabs = r_c_cn[CW]     ? -r_c_cn : r_c_cn;
        n_den    = v_dabs[DW-1:0];
        n_num[0] = XW'(v_aabs) << SH_A;
        n_num[1] = XW'(v_babs) << SH_BC;
        n_num[2] = XW'(v_cabs) << SH_BC;
        n_dm        = r_cm;
        n_dm.degen  = (r_det == '0);
        n_dm.neg[0] = r_an[2*CW]  ^ r_det[2*CW+2];
        n_dm.neg[1] = r_c_bn[CW]  ^ r_det[2*CW+2];
        n_dm.neg[2] = r_c_cn[CW]  ^ r_det[2*CW+2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dm  <= n_dm;
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    // ---------------- divider with side data delay line ----------------
    logic [NROW-1:0][NS-1:0] w_q;
    logic                    r_qv [NS];
    t_meta                   r_qm [NS];

    p1tri_divider #(
        .DW (DW),
        .NS (NS),
        .NL (NROW)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num),
        .i_den (r_den),
        .o_q   (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qm[0] <= r_dm;
            for (int s = 1; s < NS; s++) r_qm[s] <= r_qm[s-1];
        end
    end

    // ---------------- stage E: round and saturate coefficients ----------------
    logic                 r_ev;
    t_meta                r_em;
    logic signed [OW-1:0] r_e_coef [NROW];
    logic signed [OW-1:0] n_e_coef [NROW];

    always_comb begin
        logic [NS-1:0] v_rnd;
        for (int l = 0; l < NROW; l++) begin
            v_rnd       = {1'b0, w_q[l][NS-2:0]} + NS'(1);
            n_e_coef[l] = sat32(r_qm[NS-1].neg[l], 64'(v_rnd[NS-1:1]), w_q[l][NS-1]);
            if (r_qm[NS-1].degen) n_e_coef[l] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_em <= r_qm[NS-1];
            for (int l = 0; l < NROW; l++) r_e_coef[l] <= n_e_coef[l];
        end
    end

    // ---------------- row collector and stiffness buffer ----------------
    logic signed [OW-1:0] r_col_a [2], r_col_b [2], r_col_c [2];
    logic signed [OW-1:0] r_kb_a [NROW], r_kb_b [NROW], r_kb_c [NROW];
    logic [CW-1:0]        r_kb_area;
    logic                 r_kb_degen;
    logic                 r_kv;
    logic [1:0]           r_kcnt;
    logic                 w_load;

    assign w_load = w_en && r_ev && r_em.row == ROW_LAST;

    always_ff @(posedge i_clk) begin
        if (w_en && r_ev && r_em.row != ROW_LAST) begin
            r_col_a[r_em.row[0]] <= r_e_coef[0];
            r_col_b[r_em.row[0]] <= r_e_coef[1];
            r_col_c[r_em.row[0]] <= r_e_coef[2];
        end
        if (w_load) begin
            r_kb_a[0] <= r_col_a[0]; r_kb_a[1] <= r_col_a[1]; r_kb_a[2] <= r_e_coef[0];
            r_kb_b[0] <= r_col_b[0]; r_kb_b[1] <= r_col_b[1]; r_kb_b[2] <= r_e_coef[1];
            r_kb_c[0] <= r_col_c[0]; r_kb_c[1] <= r_col_c[1]; r_kb_c[2] <= r_e_coef[2];
            r_kb_area  <= r_em.area;
            r_kb_degen <= r_em.degen;
        end
    end

    // ---------------- K1: pairwise gradient products ----------------
    logic                   r_k1v;
    t_krow                  r_k1r, n_k1r;
    logic signed [2*OW-1:0] r_k1_bb [NROW], r_k1_cc [NROW];

    always_comb begin
        n_k1r       = '0;
        n_k1r.row   = r_kcnt;
        n_k1r.degen = r_kb_degen;
        n_k1r.area  = r_kb_area;
        unique case (r_kcnt)
            ROW_MID:  begin n_k1r.a = r_kb_a[1]; n_k1r.b = r_kb_b[1]; n_k1r.c = r_kb_c[1]; end
            ROW_LAST: begin n_k1r.a = r_kb_a[2]; n_k1r.b = r_kb_b[2]; n_k1r.c = r_kb_c[2]; end
            default:  begin n_k1r.a = r_kb_a[0]; n_k1r.b = r_kb_b[0]; n_k1r.c = r_kb_c[0]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k1r <= n_k1r;
            for (int j = 0; j < NROW; j++) begin
                r_k1_bb[j] <= n_k1r.b * r_kb_b[j];
                r_k1_cc[j] <= n_k1r.c * r_kb_c[j];
            end
        end
    end

    // ---------------- K2: sum to sign-magnitude ----------------
    logic            r_k2v;
    t_krow           r_k2r;
    logic [2*OW-1:0] r_k2_mag [NROW];
    logic [NROW-1:0] r_k2_neg;

    always_ff @(posedge i_clk) begin
        logic [2*OW:0] v_sum;
        logic [2*OW:0] v_abs;
        if (w_en) begin
            r_k2r <= r_k1r;
            for (int j = 0; j < NROW; j++) begin
                v_sum = {r_k1_bb[j][2*OW-1], r_k1_bb[j]} + {r_k1_cc[j][2*OW-1], r_k1_cc[j]};
                v_abs = v_sum[2*OW] ? -v_sum : v_sum;
                r_k2_neg[j] <= v_sum[2*OW];
                r_k2_mag[j] <= v_abs[2*OW-1:0];
            end
        end
    end

    // ---------------- K3: area partial products ----------------
    logic            r_k3v;
    t_krow           r_k3r;
    logic [PW-1:0]   r_k3_lo [NROW], r_k3_hi [NROW];
    logic [NROW-1:0] r_k3_neg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k3r    <= r_k2r;
            r_k3_neg <= r_k2_neg;
            for (int j = 0; j < NROW; j++) begin
                r_k3_lo[j] <= r_k2r.area * r_k2_mag[j][OW-1:0];
                r_k3_hi[j] <= r_k2r.area * r_k2_mag[j][2*OW-1:OW];
            end
        end
    end

    // ---------------- K4: combine, round, saturate ----------------
    logic r_k4v;
    t_res r_k4, n_k4;

    always_comb begin
        logic [TW-1:0] v_tot;
        n_k4       = '0;
        n_k4.row   = r_k3r.row;
        n_k4.a     = r_k3r.a;
        n_k4.b     = r_k3r.b;
        n_k4.c     = r_k3r.c;
        n_k4.degen = r_k3r.degen;
        n_k4.last  = (r_k3r.row == ROW_LAST);
        for (int j = 0; j < NROW; j++) begin
            v_tot = (TW'(r_k3_hi[j]) << OW) + TW'(r_k3_lo[j]) + RND_K;
            n_k4.k[j] = sat32(r_k3_neg[j], 64'(v_tot[TW-1:SH_K]), 1'b0);
            if (r_k3r.degen) n_k4.k[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_k4 <= n_k4;
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av  <= 1'b0;
            r_bv  <= 1'b0;
            r_cv  <= 1'b0;
            r_dv  <= 1'b0;
            for (int s = 0; s < NS; s++) r_qv[s] <= 1'b0;
            r_ev  <= 1'b0;
            r_kv  <= 1'b0;
            r_kcnt <= ROW_FIRST;
            r_k1v <= 1'b0;
            r_k2v <= 1'b0;
            r_k3v <= 1'b0;
            r_k4v <= 1'b0;
        end else if (w_en) begin
            r_av    <= r_ser_v;
            r_bv    <= r_av;
            r_cv    <= r_bv;
            r_dv    <= r_cv;
            r_qv[0] <= r_dv;
            for (int s = 1; s < NS; s++) r_qv[s] <= r_qv[s-1];
            r_ev    <= r_qv[NS-1];
            r_k1v   <= r_kv;
            r_k2v   <= r_k1v;
            r_k3v   <= r_k2v;
            r_k4v   <= r_k3v;
            // a new element reloads the buffer; otherwise it drains one row per cycle while the pipeline is enabled
            if (w_load) begin
                r_kv   <= 1'b1;
                r_kcnt <= ROW_FIRST;
            end else if (r_kv) begin
                if (r_kcnt == ROW_LAST) r_kv <= 1'b0;
                r_kcnt <= r_kcnt + 2'd1;
            end
        end
    end

    // ---------------- output register with skid ----------------
    t_res r_out, r_skid;
    logic r_out_v;
    logic w_pop;

    assign w_pop = r_out_v && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) r_skid_v <= 1'b0;
        end else if (r_k4v) begin
            if (!r_out_v || w_pop) r_out_v <= 1'b1;
            else                   r_skid_v <= 1'b1;
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) r_out <= r_skid;
        end else if (r_k4v) begin
            if (!r_out_v || w_pop) r_out  <= r_k4;
            else                   r_skid <= r_k4;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_vertex_row = r_out.row;
    assign o_coef_const = r_out.a;
    assign o_coef_x     = r_out.b;
    assign o_coef_y     = r_out.c;
    assign o_stiff_col0 = $signed(r_out.k[0]);
    assign o_stiff_col1 = $signed(r_out.k[1]);
    assign o_stiff_col2 = $signed(r_out.k[2]);
    assign o_degenerate = r_out.degen;
    assign o_last_row   = r_out.last;

    // ---------------- assertions ----------------
    `P1_ASSERT(a_skid_has_out, r_skid_v |-> r_out_v, "skid holds an item with output empty")
    `P1_ASSERT(a_kbuf_no_overrun, (r_kv && r_kcnt != ROW_LAST) |-> !w_load, "stiffness buffer overrun")
    `P1_ASSERT(a_skid_fill, $rose(r_skid_v) |-> $past(r_out_v && !i_out_ready), "skid filled without stall")
    `P1_ASSERT(a_ser_cnt, r_ser_v |-> (r_ser_cnt == ROW_FIRST || r_ser_cnt == ROW_MID || r_ser_cnt == ROW_LAST), "row counter out of range")

endmodule

// File: sim/p1tri_row_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// p1tri_row_checker
// Watches both channels of the triangle stiffness block, predicts the three
// result rows of every accepted element and compares them in order.
// ============================================================================
module p1tri_row_checker #(
    parameter int COORD_FRAC_BITS = p1tri_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  logic signed [p1tri_pkg::CW-1:0] i_vertex0_x,
    input  logic signed [p1tri_pkg::CW-1:0] i_vertex0_y,
    input  logic signed [p1tri_pkg::CW-1:0] i_vertex1_x,
    input  logic signed [p1tri_pkg::CW-1:0] i_vertex1_y,
    input  logic signed [p1tri_pkg::CW-1:0] i_vertex2_x,
    input  logic signed [p1tri_pkg::CW-1:0] i_vertex2_y,
    input  logic [p1tri_pkg::CW-1:0]        i_element_area,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [1:0]                      o_vertex_row,
    input  logic signed [p1tri_pkg::OW-1:0] o_coef_const,
    input  logic signed [p1tri_pkg::OW-1:0] o_coef_x,
    input  logic signed [p1tri_pkg::OW-1:0] o_coef_y,
    input  logic signed [p1tri_pkg::OW-1:0] o_stiff_col0,
    input  logic signed [p1tri_pkg::OW-1:0] o_stiff_col1,
    input  logic signed [p1tri_pkg::OW-1:0] o_stiff_col2,
    input  logic                            o_degenerate,
    input  logic                            o_last_row,
    output int                              o_rows_pending,
    output int                              o_fail_count
);
    import p1tri_pkg::*;

    localparam int KSHIFT = COORD_FRAC_BITS + OUT_FRAC;

    t_res expected_rows[$];
    int   fails = 0;

    assign o_rows_pending = expected_rows.size();
    assign o_fail_count   = fails;

    // sign-magnitude to saturated Q16.16
    function automatic logic signed [OW-1:0] clamp_q16(input logic neg,
                                                       input logic [127:0] m,
                                                       input logic ovf);
        logic signed [OW-1:0] r;
        if (neg) begin
            if (ovf || m > 128'h8000_0000) r = SAT_NEG;
            else                           r = -m[OW-1:0];
        end else begin
            if (ovf || m > 128'h7FFF_FFFF) r = SAT_POS;
            else                           r = m[OW-1:0];
        end
        return r;
    endfunction

    // round(num * 2^s / den), ties away from zero; overflow once q hits 2^33
    function automatic logic signed [OW-1:0] round_quotient(input logic signed [63:0] num,
                                                            input logic signed [63:0] den,
                                                            input int s);
        logic [127:0] n, d, q;
        logic neg, ovf;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? 128'(-num) : 128'(num);
        d   = (den < 0) ? 128'(-den) : 128'(den);
        q   = (n << (s + 1)) / d;
        ovf = q >= (128'd1 << 33);
        q   = (q + 1) >> 1;
        return clamp_q16(neg, q, ovf);
    endfunction

    // area * (p1 + p2) scaled back to Q16.16
    function automatic logic signed [OW-1:0] stiffness_entry(input logic [CW-1:0] area,
                                                             input logic signed [63:0] p1,
                                                             input logic signed [63:0] p2);
        logic signed [65:0] sum;
        logic [127:0] m, t;
        sum = 66'(p1) + 66'(p2);
        m   = (sum < 0) ? 128'(-sum) : 128'(sum);
        t   = (128'(area) * m + (128'd1 << (KSHIFT - 1))) >> KSHIFT;
        return clamp_q16(sum < 0, t, t[127:64] != 0);
    endfunction

    // queue the three rows of one element
    task automatic queue_element_rows();
        logic signed [63:0] x[3], y[3];
        logic signed [63:0] det;
        logic signed [OW-1:0] ca[3], cb[3], cc[3];
        t_res row;
        int j, k;
        x[0] = i_vertex0_x; y[0] = i_vertex0_y;
        x[1] = i_vertex1_x; y[1] = i_vertex1_y;
        x[2] = i_vertex2_x; y[2] = i_vertex2_y;
        det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
        for (int i = 0; i < NROW; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            if (det == 0) begin
                ca[i] = '0; cb[i] = '0; cc[i] = '0;
            end else begin
                ca[i] = round_quotient(x[j] * y[k] - x[k] * y[j], det, OUT_FRAC);
                cb[i] = round_quotient(y[j] - y[k], det, KSHIFT);
                cc[i] = round_quotient(x[k] - x[j], det, KSHIFT);
            end
        end
        for (int i = 0; i < NROW; i++) begin
            row.row = 2'(i);
            row.a = ca[i];
            row.b = cb[i];
            row.c = cc[i];
            for (int c = 0; c < NROW; c++) begin
                if (det == 0) row.k[c] = '0;
                else row.k[c] = stiffness_entry(i_element_area,
                                                64'(cb[i]) * 64'(cb[c]),
                                                64'(cc[i]) * 64'(cc[c]));
            end
            row.degen = det == 0;
            row.last  = 2'(i) == ROW_LAST;
            expected_rows.push_back(row);
        end
    endtask

    task automatic check_field(input string name, input logic signed [OW-1:0] exp_v,
                               input logic signed [OW-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    // compare outgoing rows, then record the new element
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    $error("row %0d arrived with nothing expected", o_vertex_row);
                    fails++;
                end else begin
                    e = expected_rows.pop_front();
                    check_field("vertex_row", 32'(e.row), 32'(o_vertex_row));
                    check_field("coef_const", e.a, o_coef_const);
                    check_field("coef_x", e.b, o_coef_x);
                    check_field("coef_y", e.c, o_coef_y);
                    check_field("stiff_col0", e.k[0], o_stiff_col0);
                    check_field("stiff_col1", e.k[1], o_stiff_col1);
                    check_field("stiff_col2", e.k[2], o_stiff_col2);
                    check_field("degenerate", 32'(e.degen), 32'(o_degenerate));
                    check_field("last_row", 32'(e.last), 32'(o_last_row));
                end
            end
            if (i_in_valid && o_in_ready) queue_element_rows();
        end
    end

endmodule

// File: sim/p1_triangle_element_stiffness_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// p1_triangle_element_stiffness_tb
// Feeds directed and random triangles to the stiffness block with random
// gaps and output stalls; the row checker predicts and compares every row.
// ============================================================================
module p1_triangle_element_stiffness_tb;
    import p1tri_pkg::*;

    localparam int N_RANDOM = 220;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [CW-1:0] i_vertex0_x = '0, i_vertex0_y = '0;
    logic signed [CW-1:0] i_vertex1_x = '0, i_vertex1_y = '0;
    logic signed [CW-1:0] i_vertex2_x = '0, i_vertex2_y = '0;
    logic [CW-1:0] i_element_area = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_vertex_row;
    logic signed [OW-1:0] o_coef_const, o_coef_x, o_coef_y;
    logic signed [OW-1:0] o_stiff_col0, o_stiff_col1, o_stiff_col2;
    logic o_degenerate, o_last_row;
    int   rows_pending, fail_count;
    logic steady = 1'b0;   // no idling on either side while set

    always #5 i_clk = ~i_clk;

    p1_triangle_element_stiffness uut (.*);

    p1tri_row_checker chk (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready,
        .i_vertex0_x, .i_vertex0_y, .i_vertex1_x, .i_vertex1_y,
        .i_vertex2_x, .i_vertex2_y, .i_element_area,
        .o_out_valid, .i_out_ready, .o_vertex_row,
        .o_coef_const, .o_coef_x, .o_coef_y,
        .o_stiff_col0, .o_stiff_col1, .o_stiff_col2,
        .o_degenerate, .o_last_row,
        .o_rows_pending(rows_pending), .o_fail_count(fail_count)
    );

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && (steady || $urandom_range(99) >= 22);
    end

    // present one element at a falling edge and hold it until accepted
    task automatic send_triangle(input logic [CW-1:0] x0, y0, x1, y1, x2, y2, area);
        if (!steady && $urandom_range(99) < 22) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_vertex0_x = x0; i_vertex0_y = y0;
        i_vertex1_x = x1; i_vertex1_y = y1;
        i_vertex2_x = x2; i_vertex2_y = y2;
        i_element_area = area;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(input int shift);
        return CW'($signed(CW'($urandom)) >>> shift);
    endfunction

    // random element: mostly well-formed, some collinear, some raw noise
    task automatic send_random_triangle();
        logic [CW-1:0] x0, y0, dx1, dy1, dx2, dy2, area;
        int kind, sh;
        kind = $urandom_range(99);
        sh   = $urandom_range(22, 4);
        x0 = rand_coord($urandom_range(8, 0));
        y0 = rand_coord($urandom_range(8, 0));
        dx1 = rand_coord(sh); dy1 = rand_coord(sh);
        dx2 = rand_coord(sh); dy2 = rand_coord(sh);
        area = CW'($urandom) >> $urandom_range(23, 0);
        if (kind < 75) begin
            send_triangle(x0, y0, x0 + dx1, y0 + dy1, x0 + dx2, y0 + dy2, area);
        end else if (kind < 85) begin
            send_triangle(x0, y0, x0 + dx1, y0 + dy1, x0 + dx1 + dx1, y0 + dy1 + dy1, area);
        end else begin
            send_triangle(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                          CW'($urandom), CW'($urandom), CW'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: unit triangle, both orientations, extremes, degenerate cases
        send_triangle(24'h0, 24'h0, 24'h010000, 24'h0, 24'h0, 24'h010000, 24'h008000);
        send_triangle(24'h0, 24'h0, 24'h0, 24'h010000, 24'h010000, 24'h0, 24'h008000);
        send_triangle(24'h0, 24'h0, 24'h000001, 24'h0, 24'h0, 24'h000001, 24'hFFFFFF);
        send_triangle(24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000,
                      24'h800000, 24'h7FFFFF, 24'hFFFFFF);
        send_triangle(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                      24'h7FFFFF, 24'h800000, 24'h000001);
        send_triangle(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
                      24'h7FFFFF, 24'h7FFFFF, 24'h0);
        send_triangle(24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h010000);
        send_triangle(24'h010000, 24'h020000, 24'h020000, 24'h040000,
                      24'h030000, 24'h060000, 24'h010000);
        send_triangle(24'h010000, 24'h010000, 24'h010000, 24'h010000,
                      24'h050000, 24'h020000, 24'hFFFFFF);
        send_triangle(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE, 24'h7FFFFF,
                      24'h7FFFFF, 24'h7FFFFE, 24'hFFFFFF);
        send_triangle(24'h400000, 24'hC00000, 24'h000001, 24'h000002,
                      24'hFFFFFF, 24'h000003, 24'h123456);
        send_triangle(24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 60) steady = 1'b1;
            if (n == 120) steady = 1'b0;
            // hold off until the pipeline has drained once
            if (n == 160) begin
                i_in_valid = 1'b0;
                while (rows_pending != 0) @(negedge i_clk);
            end
            send_random_triangle();
        end
        i_in_valid = 1'b0;

        while (rows_pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
